// ===== design/slbm_pkg.sv =====
`default_nettype none

package slbm_pkg;

  // width of the saturating drop counter (8 to 64)
  localparam int unsigned IGNORE_COUNT_WIDTH = 32;

  // modulo unit: numerator bits, one per step
  localparam int unsigned NumW   = 5;
  localparam int unsigned StepW  = $clog2(NumW);
  localparam int unsigned CfgIdxW = 8;

  // request kinds
  typedef enum logic [1:0] {
    REQ_WRITE     = 2'd0,
    REQ_TIMED     = 2'd1,
    REQ_PRG_QUERY = 2'd2,
    REQ_CHR_QUERY = 2'd3
  } req_type_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRG_COUNT = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_CHR_COUNT = CfgIdxW'(1);

  // serial loader targets, from address bits 14-13
  typedef enum logic [1:0] {
    TGT_CONTROL = 2'd0,
    TGT_CHR_LO  = 2'd1,
    TGT_CHR_HI  = 2'd2,
    TGT_PROGRAM = 2'd3
  } target_e;

  // program mapping modes from control bits 3-2; the others switch 32K at a time
  localparam logic [1:0] PrgModeFixFirst = 2'd2;
  localparam logic [1:0] PrgModeFixLast  = 2'd3;

  localparam logic [4:0] CtrlReset   = 5'h0c;
  localparam logic [7:0] BankOutside = 8'hff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [63:0] bus_cycle;
  } in_t;

  typedef struct packed {
    logic [7:0]  bank;
    logic        write_ignored;
    logic [2:0]  bits_loaded;
    logic [31:0] ignored_total;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/serial_loaded_bank_mapper.sv =====
// Serial-loaded cartridge bank mapper. Each input item (plain write, timed write,
// program-bank query or pattern-bank query) gives one result. After its transfer an
// item goes through a set-up state, five steps of the bit-serial modulo unit (one
// numerator bit per cycle) that reduces the bank number by the configured bank count,
// and a commit that updates state and loads the output register; the block then
// returns to idle, where the next transfer is taken. The result waits in the output
// register, so the next item can be taken while it is still unread; a commit waits
// only while that register is full and not being read.
// Configuration writes are taken in any cycle and must be made while the block is idle.
`default_nettype none

module serial_loaded_bank_mapper (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire slbm_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output slbm_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [slbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i
);

  slbm_pkg::cmd_t    cmd;
  slbm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  slbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // registers, modulo unit and output stage
  slbm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/slbm_ctrl.sv =====
`default_nettype none

module slbm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire slbm_pkg::status_t status_i,
  output slbm_pkg::cmd_t        cmd_o
);

  slbm_pkg::state_e state_q, state_d;
  logic [slbm_pkg::StepW-1:0] step_q, step_d;
  logic last_step;

  assign last_step = (step_q == slbm_pkg::StepW'(slbm_pkg::NumW - 1));

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slbm_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      slbm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = slbm_pkg::ST_INIT;
      end
      slbm_pkg::ST_INIT: begin
        state_d = slbm_pkg::ST_STEP;
        step_d  = '0;
      end
      slbm_pkg::ST_STEP: begin
        if (last_step) state_d = slbm_pkg::ST_DONE;
        else step_d = step_q + 1'b1;
      end
      slbm_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = slbm_pkg::ST_IDLE;
      end
      default: state_d = slbm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      slbm_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      slbm_pkg::ST_INIT: cmd_o.div_init = 1'b1;
      slbm_pkg::ST_STEP: cmd_o.div_step = 1'b1;
      slbm_pkg::ST_DONE: cmd_o.commit   = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/slbm_dpath.sv =====
`default_nettype none

module slbm_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire slbm_pkg::in_t                 in_data_i,
  input  wire slbm_pkg::cmd_t                cmd_i,
  output slbm_pkg::status_t                  status_o,
  input  wire logic                          cfg_write_i,
  input  wire logic [slbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output slbm_pkg::out_t                     out_data_o
);

  localparam int unsigned CntW = slbm_pkg::IGNORE_COUNT_WIDTH;

  // configuration
  logic [7:0] prg_cnt_q, chr_cnt_q;
  // mapper state
  logic [4:0]  shift_bits_q, shift_bits_d;
  logic [2:0]  shift_fill_q, shift_fill_d;
  logic [4:0]  ctrl_q, ctrl_d;
  logic [4:0]  chr_lo_q, chr_lo_d;
  logic [4:0]  chr_hi_q, chr_hi_d;
  logic [4:0]  prg_q, prg_d;
  logic [63:0] last_cycle_q, last_cycle_d;
  logic        last_valid_q, last_valid_d;
  logic [CntW-1:0] ign_q, ign_d;
  // item and modulo unit
  slbm_pkg::in_t item_q;
  logic [slbm_pkg::NumW-1:0] num_q;
  logic [7:0] rem_q;
  logic [7:0] div_q;
  // output register
  logic   out_valid_q;
  slbm_pkg::out_t out_q;

  logic [7:0] prg_eff, chr_eff;
  logic [slbm_pkg::NumW-1:0] num_init;
  logic [8:0] rem_shift;
  logic [8:0] rem_next;
  logic [7:0] bank_res;
  logic [8:0] pair_sum;
  logic       hi_half;
  logic       in_window;
  logic       back_to_back;
  logic       dropped;
  logic       do_load;
  logic [4:0] merged;
  logic [2:0] fill_inc;
  logic [63:0] ign_ext;
  logic [31:0] shown;

  assign prg_eff = (prg_cnt_q == 8'd0) ? 8'd1 : prg_cnt_q;
  assign chr_eff = (chr_cnt_q == 8'd0) ? 8'd1 : chr_cnt_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= 8'd8;
      chr_cnt_q <= 8'd8;
    end else if (cfg_write_i) begin
      if (cfg_index_i == slbm_pkg::CFG_PRG_COUNT) prg_cnt_q <= cfg_data_i;
      if (cfg_index_i == slbm_pkg::CFG_CHR_COUNT) chr_cnt_q <= cfg_data_i;
    end
  end

  // numerator for the query
  always_comb begin
    if (item_q.req_type == slbm_pkg::REQ_PRG_QUERY) begin
      num_init = {1'b0, prg_q[3:0]};
    end else if (!ctrl_q[4]) begin
      num_init = {chr_lo_q[4:1], item_q.addr[12]};
    end else begin
      num_init = item_q.addr[12] ? chr_hi_q : chr_lo_q;
    end
  end

  // one restoring step of the remainder
  assign rem_shift = {rem_q, num_q[slbm_pkg::NumW-1]};
  assign rem_next  = (rem_shift >= {1'b0, div_q}) ? rem_shift - {1'b0, div_q} : rem_shift;

  // item register and modulo unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.div_init) begin
      num_q <= num_init;
      rem_q <= '0;
      div_q <= (item_q.req_type == slbm_pkg::REQ_PRG_QUERY) ? prg_eff : chr_eff;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[slbm_pkg::NumW-2:0], 1'b0};
      rem_q <= rem_next[7:0];
    end
  end

  // bank result from the remainder
  assign hi_half  = item_q.addr[14];
  assign pair_sum = {1'b0, rem_q[7:1], 1'b0} + {8'd0, hi_half};
  always_comb begin
    bank_res = 8'd0;
    unique case (item_q.req_type)
      slbm_pkg::REQ_PRG_QUERY: begin
        if (!item_q.addr[15]) begin
          bank_res = slbm_pkg::BankOutside;
        end else begin
          unique case (ctrl_q[3:2])
            slbm_pkg::PrgModeFixFirst: bank_res = hi_half ? rem_q : 8'd0;
            slbm_pkg::PrgModeFixLast:  bank_res = hi_half ? prg_eff - 8'd1 : rem_q;
            default: begin
              bank_res = (pair_sum >= {1'b0, prg_eff}) ?
                         8'(pair_sum - {1'b0, prg_eff}) : pair_sum[7:0];
            end
          endcase
        end
      end
      slbm_pkg::REQ_CHR_QUERY: begin
        bank_res = (item_q.addr[15:13] != 3'd0) ? slbm_pkg::BankOutside : rem_q;
      end
      default: bank_res = 8'd0;
    endcase
  end

  // write handling
  assign in_window    = item_q.addr[15];
  assign back_to_back = last_valid_q && (item_q.bus_cycle == last_cycle_q + 64'd1);
  assign dropped      = (item_q.req_type == slbm_pkg::REQ_TIMED) && in_window &&
                        !item_q.value[7] && back_to_back;
  assign do_load      = in_window && !dropped &&
                        ((item_q.req_type == slbm_pkg::REQ_WRITE) ||
                         (item_q.req_type == slbm_pkg::REQ_TIMED));
  assign merged   = shift_bits_q | (5'(item_q.value[0]) << shift_fill_q);
  assign fill_inc = shift_fill_q + 3'd1;

  always_comb begin
    shift_bits_d = shift_bits_q;
    shift_fill_d = shift_fill_q;
    ctrl_d       = ctrl_q;
    chr_lo_d     = chr_lo_q;
    chr_hi_d     = chr_hi_q;
    prg_d        = prg_q;
    last_cycle_d = last_cycle_q;
    last_valid_d = last_valid_q;
    ign_d        = ign_q;
    // cycle tracking for in-window timed writes
    if ((item_q.req_type == slbm_pkg::REQ_TIMED) && in_window) begin
      last_cycle_d = item_q.bus_cycle;
      last_valid_d = 1'b1;
    end
    if (dropped && (ign_q != '1)) ign_d = ign_q + 1'b1;
    // serial loader
    if (do_load) begin
      if (item_q.value[7]) begin
        shift_bits_d = '0;
        shift_fill_d = '0;
        ctrl_d       = ctrl_q | slbm_pkg::CtrlReset;
      end else if (fill_inc == 3'd5) begin
        shift_bits_d = '0;
        shift_fill_d = '0;
        unique case (slbm_pkg::target_e'(item_q.addr[14:13]))
          slbm_pkg::TGT_CONTROL: ctrl_d   = merged;
          slbm_pkg::TGT_CHR_LO:  chr_lo_d = merged;
          slbm_pkg::TGT_CHR_HI:  chr_hi_d = merged;
          slbm_pkg::TGT_PROGRAM: prg_d    = merged;
          default: ;
        endcase
      end else begin
        shift_bits_d = merged;
        shift_fill_d = fill_inc;
      end
    end
  end

  // displayed count saturates at 32 bits
  assign ign_ext = 64'(ign_d);
  assign shown   = (ign_ext[63:32] != 32'd0) ? 32'hffff_ffff : ign_ext[31:0];

  // mapper state update at commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_bits_q <= '0;
      shift_fill_q <= '0;
      ctrl_q       <= slbm_pkg::CtrlReset;
      chr_lo_q     <= '0;
      chr_hi_q     <= '0;
      prg_q        <= '0;
      last_cycle_q <= '0;
      last_valid_q <= 1'b0;
      ign_q        <= '0;
    end else if (cmd_i.commit) begin
      shift_bits_q <= shift_bits_d;
      shift_fill_q <= shift_fill_d;
      ctrl_q       <= ctrl_d;
      chr_lo_q     <= chr_lo_d;
      chr_hi_q     <= chr_hi_d;
      prg_q        <= prg_d;
      last_cycle_q <= last_cycle_d;
      last_valid_q <= last_valid_d;
      ign_q        <= ign_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.bank          <= bank_res;
      out_q.write_ignored <= dropped;
      out_q.bits_loaded   <= shift_fill_d;
      out_q.ignored_total <= shown;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/slbm_checker.sv =====
`default_nettype none

module slbm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire slbm_pkg::out_t                out_data_o
);

  // result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // busy after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // loader never reports a full register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bits_loaded <= 3'd4)
    else $error("bits_loaded out of range");

  // a dropped write is a write and has no bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_ignored |-> out_data_o.bank == 8'd0)
    else $error("dropped write shows a bank");

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (.*);

`default_nettype wire
